[rtl/srarq_pkg.sv]
`default_nettype none

package srarq_pkg;

    localparam int WINDOW_MAX_DEF = 16;
    localparam int SEQ_WIDTH_DEF  = 16;

    localparam int TIMER_W    = 16;
    // wide enough for any window depth up to 64
    localparam int CELL_POS_W = 6;
    localparam int OCC_W      = CELL_POS_W + 1;

    localparam logic [4:0]  WINDOW_RST  = 5'd4;
    localparam logic [15:0] LIMIT_RST   = 16'd15;
    localparam logic [15:0] TIMEOUT_RST = 16'd2000;

    localparam logic [1:0] CFG_WINDOW  = 2'd0;
    localparam logic [1:0] CFG_LIMIT   = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT = 2'd2;

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_DATA  = 2'd1,
        FUNC_ACK   = 2'd2,
        FUNC_TICK  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        KIND_NEW  = 2'd0,
        KIND_ACK  = 2'd1,
        KIND_RETX = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SLIDE,
        ST_FILL,
        ST_TICK,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [4:0]  window_size;
        logic [15:0] packet_limit;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic               acked;
        logic               running;
        logic [TIMER_W-1:0] timer;
    } cell_t;

    typedef struct packed {
        logic                  rotate;
        logic                  tick;
        logic                  mark;
        logic                  load;
        logic [CELL_POS_W-1:0] pos;
        logic [TIMER_W-1:0]    reload;
    } cell_cmd_t;

    typedef struct packed {
        logic             idle;
        logic [OCC_W-1:0] occ;
    } ctrl_stat_t;

endpackage

`default_nettype wire

[rtl/srarq_cell.sv]
`default_nettype none

module srarq_cell
    import srarq_pkg::*;
#(
    parameter int POS = 0
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_cmd_t cmd,
    input  wire cell_t     nb,
    output cell_t          pass,
    output logic           expire
);

    localparam logic AT_HEAD = (POS == 0);
    localparam logic [CELL_POS_W-1:0] MY_POS = CELL_POS_W'(POS);

    cell_t st_reg;
    cell_t st_next;
    cell_t ticked;
    logic  exp_w;
    logic [TIMER_W-1:0] dec;

    // timer step applied when this cell sits at the head of the ring
    always_comb
    begin
        ticked = st_reg;
        exp_w  = 1'b0;
        dec    = (st_reg.timer != '0) ? st_reg.timer - 1'b1 : st_reg.timer;
        if (st_reg.running)
        begin
            if (dec == '0)
            begin
                exp_w        = 1'b1;
                ticked.timer = cmd.reload;
            end
            else
            begin
                ticked.timer = dec;
            end
        end
    end

    assign pass   = (AT_HEAD && cmd.tick) ? ticked : st_reg;
    assign expire = AT_HEAD && cmd.tick && exp_w;

    always_comb
    begin
        st_next = st_reg;
        if (cmd.rotate)
        begin
            st_next = nb;
        end
        else if (cmd.mark && cmd.pos == MY_POS)
        begin
            st_next.acked   = 1'b1;
            st_next.running = 1'b0;
            st_next.timer   = '0;
        end
        else if (cmd.load && cmd.pos == MY_POS)
        begin
            st_next.acked   = 1'b0;
            st_next.running = 1'b1;
            st_next.timer   = cmd.reload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

endmodule

`default_nettype wire

[rtl/srarq_ctrl.sv]
`default_nettype none

module srarq_ctrl
    import srarq_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF,
    parameter int SEQ_WIDTH  = SEQ_WIDTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire func_t       in_func,
    input  wire logic [15:0] in_seq,
    input  wire cell_t       head,
    input  wire logic        head_expire,
    output cell_cmd_t        cmd,
    output ctrl_stat_t       stat,
    output logic             out_valid,
    input  wire logic        out_ready,
    output kind_t            out_kind,
    output logic [15:0]      out_seq,
    output logic             out_last,
    output logic             out_all_acked
);

    localparam int KW   = $clog2(WINDOW_MAX + 1);
    localparam int CMPW = (SEQ_WIDTH > KW) ? SEQ_WIDTH : KW;
    localparam int LW   = (SEQ_WIDTH > 16) ? SEQ_WIDTH : 16;
    localparam logic [SEQ_WIDTH-1:0] SEQ_MASK = '1;

    state_t               state_reg, state_next;
    logic [SEQ_WIDTH-1:0] base_reg, base_next;
    logic [SEQ_WIDTH-1:0] next_reg, next_next;
    logic [KW-1:0]        k_reg, k_next;
    logic                 pend_valid_reg, pend_valid_next;
    kind_t                pend_kind_reg, pend_kind_next;
    logic [15:0]          pend_seq_reg, pend_seq_next;

    logic                 out_valid_reg;
    kind_t                out_kind_reg;
    logic [15:0]          out_seq_reg;
    logic                 out_last_reg;
    logic                 out_all_reg;

    logic [4:0]           eff_win;
    logic [SEQ_WIDTH-1:0] eff_lim;
    logic [TIMER_W-1:0]   eff_to;
    logic [SEQ_WIDTH-1:0] occ;
    logic [SEQ_WIDTH-1:0] seq_in;
    logic                 in_win;
    logic                 out_free;
    logic                 all_acked_w;
    logic                 tick_live;
    logic                 emit;
    kind_t                emit_kind;
    logic [15:0]          emit_seq;
    logic                 flush;
    logic                 out_load;
    logic                 out_last_flag;

    always_comb
    begin
        if (cfg.window_size == '0)
        begin
            eff_win = 5'd1;
        end
        else if (7'(cfg.window_size) > 7'(WINDOW_MAX))
        begin
            eff_win = 5'(WINDOW_MAX);
        end
        else
        begin
            eff_win = cfg.window_size;
        end
    end

    assign eff_lim = (LW'(cfg.packet_limit) < LW'(SEQ_MASK)) ?
                     SEQ_WIDTH'(cfg.packet_limit) : SEQ_MASK;
    assign eff_to  = (cfg.timeout_ticks == '0) ? TIMER_W'(1) : cfg.timeout_ticks;

    // base never passes next and neither wraps, so occ is the live window count
    assign occ         = next_reg - base_reg;
    assign seq_in      = SEQ_WIDTH'(in_seq);
    assign in_win      = (seq_in >= base_reg) && (seq_in < next_reg);
    assign out_free    = !out_valid_reg || out_ready;
    assign all_acked_w = LW'(base_reg) >= LW'(cfg.packet_limit);
    assign tick_live   = CMPW'(k_reg) < CMPW'(occ);

    always_comb
    begin
        state_next = state_reg;
        base_next  = base_reg;
        next_next  = next_reg;
        k_next     = k_reg;
        cmd        = '0;
        cmd.reload = eff_to;
        in_ready   = 1'b0;
        emit       = 1'b0;
        emit_kind  = KIND_NEW;
        emit_seq   = '0;
        flush      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_func)
                        FUNC_START:
                        begin
                            state_next = ST_FILL;
                        end
                        FUNC_DATA:
                        begin
                            emit       = 1'b1;
                            emit_kind  = KIND_ACK;
                            emit_seq   = in_seq;
                            state_next = ST_FLUSH;
                        end
                        FUNC_ACK:
                        begin
                            if (in_win)
                            begin
                                cmd.mark = 1'b1;
                                cmd.pos  = CELL_POS_W'(seq_in - base_reg);
                                if (seq_in == base_reg)
                                begin
                                    state_next = ST_SLIDE;
                                end
                            end
                        end
                        FUNC_TICK:
                        begin
                            k_next     = '0;
                            state_next = ST_TICK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SLIDE:
            begin
                if (base_reg < next_reg && base_reg < eff_lim && head.acked)
                begin
                    cmd.rotate = 1'b1;
                    base_next  = base_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if ((SEQ_WIDTH + 1)'(occ) < (SEQ_WIDTH + 1)'(eff_win) && next_reg < eff_lim)
                begin
                    if (out_free)
                    begin
                        cmd.load  = 1'b1;
                        cmd.pos   = CELL_POS_W'(occ);
                        emit      = 1'b1;
                        emit_kind = KIND_NEW;
                        emit_seq  = 16'(next_reg);
                        next_next = next_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_TICK:
            begin
                // one full lap of the ring restores the slot alignment to base
                if (k_reg == KW'(WINDOW_MAX))
                begin
                    state_next = ST_FLUSH;
                end
                else if (out_free)
                begin
                    cmd.rotate = 1'b1;
                    cmd.tick   = tick_live;
                    k_next     = k_reg + 1'b1;
                    if (tick_live && head_expire)
                    begin
                        emit      = 1'b1;
                        emit_kind = KIND_RETX;
                        emit_seq  = 16'(base_reg + SEQ_WIDTH'(k_reg));
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    flush      = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a result is held back one step so that the final one can carry last
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_seq_next   = pend_seq_reg;
        out_load        = 1'b0;
        out_last_flag   = 1'b0;
        if (emit)
        begin
            out_load        = pend_valid_reg;
            pend_valid_next = 1'b1;
            pend_kind_next  = emit_kind;
            pend_seq_next   = emit_seq;
        end
        if (flush)
        begin
            out_load        = 1'b1;
            out_last_flag   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            base_reg       <= '0;
            next_reg       <= '0;
            k_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            base_reg       <= base_next;
            next_reg       <= next_next;
            k_reg          <= k_next;
            pend_valid_reg <= pend_valid_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_kind_reg <= pend_kind_next;
        pend_seq_reg  <= pend_seq_next;
        if (out_load)
        begin
            out_kind_reg <= pend_kind_reg;
            out_seq_reg  <= pend_seq_reg;
            out_last_reg <= out_last_flag;
            out_all_reg  <= all_acked_w;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_kind      = out_kind_reg;
    assign out_seq       = out_seq_reg;
    assign out_last      = out_last_reg;
    assign out_all_acked = out_all_reg;

    assign stat.idle = (state_reg == ST_IDLE);
    assign stat.occ  = OCC_W'(occ);

endmodule

`default_nettype wire

[rtl/selective_repeat_arq_endpoint_unit.sv]
// Channel   Signals                           Payload
// s_axis    tvalid tready tdata tuser         tdata[15:0] seq_num, tuser[1:0] func
// m_axis    tvalid tready tdata tuser tlast   tdata[15:0] out_seq, tdata[16] all_acked,
//                                             tuser[1:0] out_kind, tlast last
// cfg       valid ready index data            index 0 window, 1 limit, 2 timeout
//
// One item at a time. A data item sends its ACK, a tick takes one lap of the
// slot ring, a start sends new items until the window is full, and an ack for
// the base first slides the window and then fills it; any other ack marks its slot.
// The slot ring rotates one cell per cycle; during a tick lap a stalled m_axis holds it.
// Reset clears the window, all slot cells and the config to 4 / 15 / 2000.
// A stalled m_axis holds the fill, tick and flush steps; s_axis is ready only when idle.
`default_nettype none

module selective_repeat_arq_endpoint_unit
    import srarq_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF,
    parameter int SEQ_WIDTH  = SEQ_WIDTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] seq_num
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] func

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [15:0] out_seq, [16] all_acked
    output logic [1:0]       m_axis_tuser,   // [1:0] out_kind
    output logic             m_axis_tlast,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    cfg_t       cfg_reg;
    cell_cmd_t  cmd;
    ctrl_stat_t stat;
    cell_t      pass_w [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] expire_w;
    kind_t      out_kind;
    logic [15:0] out_seq;
    logic       out_all_acked;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_size   <= WINDOW_RST;
            cfg_reg.packet_limit  <= LIMIT_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_WINDOW:  cfg_reg.window_size   <= cfg_data[4:0];
                CFG_LIMIT:   cfg_reg.packet_limit  <= cfg_data;
                CFG_TIMEOUT: cfg_reg.timeout_ticks <= cfg_data;
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    // cell p holds the slot of base + p; rotating moves the head to the tail
    for (genvar p = 0; p < WINDOW_MAX; p++)
    begin : g_cell
        srarq_cell #(
            .POS (p)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .cmd    (cmd),
            .nb     (pass_w[(p + 1) % WINDOW_MAX]),
            .pass   (pass_w[p]),
            .expire (expire_w[p])
        );
    end

    srarq_ctrl #(
        .WINDOW_MAX (WINDOW_MAX),
        .SEQ_WIDTH  (SEQ_WIDTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_func       (func_t'(s_axis_tuser)),
        .in_seq        (s_axis_tdata),
        .head          (pass_w[0]),
        .head_expire   (|expire_w),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_kind      (out_kind),
        .out_seq       (out_seq),
        .out_last      (m_axis_tlast),
        .out_all_acked (out_all_acked)
    );

    assign m_axis_tuser = out_kind;
    assign m_axis_tdata = {7'b0, out_all_acked, out_seq};

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.occ <= OCC_W'(WINDOW_MAX))
        else $error("window holds more items than slots");

    a_rotate_alone: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rotate |-> !cmd.mark && !cmd.load)
        else $error("ring rotation collides with a slot write");

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_TICK) |=>
            !s_axis_tready && !stat.idle)
        else $error("tick item did not start a ring lap");

endmodule

`default_nettype wire
